@@ src/cvfc_pkg.sv @@
// cvfc_pkg: shared constants and types for the cell voltage fault check block
// used by cvfc_cell_store, cvfc_scan_unit and cell_voltage_fault_check_core
package cvfc_pkg;

	localparam int SIDES           = 2;
	localparam int GROUPS_PER_SIDE = 16;
	localparam int CELL_COUNT      = SIDES * GROUPS_PER_SIDE;
	localparam int CELL_IDX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

	localparam int MV_W      = 16;
	localparam int SLOT_W    = 5;
	localparam int CODE_W    = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CODE_W-1:0] NO_CELL = 8'hFF;

	localparam logic KIND_STORE = 1'b0;
	localparam logic KIND_CHECK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_OVER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UNDER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPREAD = 2'd2;

	localparam logic [MV_W-1:0] OVER_RESET   = 16'd4200;
	localparam logic [MV_W-1:0] UNDER_RESET  = 16'd2500;
	localparam logic [MV_W-1:0] SPREAD_RESET = 16'd300;

	typedef enum logic [1:0] {
		FK_OVER   = 2'd0,
		FK_UNDER  = 2'd1,
		FK_SPREAD = 2'd2
	} fault_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic              start;
		logic [MV_W-1:0]   mean;
	} scan_cmd_t;

	typedef struct packed {
		logic              done;
		logic [CODE_W-1:0] code;
	} scan_res_t;

endpackage

@@ src/cvfc_cell_store.sv @@
// cvfc_cell_store: per-cell millivolt readings, one write and one registered read port
// unwritten entries read as zero through per-entry valid bits; uses cvfc_pkg
module cvfc_cell_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [cvfc_pkg::CELL_IDX_W-1:0]   waddr,
	input  logic [cvfc_pkg::MV_W-1:0]         wdata,
	input  logic [cvfc_pkg::CELL_IDX_W-1:0]   raddr,
	output logic [cvfc_pkg::MV_W-1:0]         rdata
);

	logic [cvfc_pkg::MV_W-1:0]       mem_q [cvfc_pkg::CELL_COUNT];
	logic [cvfc_pkg::CELL_COUNT-1:0] vld_q;
	logic [cvfc_pkg::MV_W-1:0]       rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= vld_q[raddr] ? mem_q[raddr] : '0;
	end

	assign rdata = rdata_q;

endmodule

@@ src/cvfc_scan_unit.sv @@
// cvfc_scan_unit: walks all cells, one per cycle, through a shared
// absolute-difference and compare unit to find the cell furthest from the mean
// the compare runs in the cycle after its read address; uses cvfc_pkg
module cvfc_scan_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cvfc_pkg::scan_cmd_t               cmd,
	output logic [cvfc_pkg::CELL_IDX_W-1:0]   raddr,
	input  logic [cvfc_pkg::MV_W-1:0]         rdata,
	output cvfc_pkg::scan_res_t               res
);

	logic                              busy_q;
	logic                              done_q;
	logic [cvfc_pkg::CELL_IDX_W-1:0]   idx_q;
	logic                              cmp_vld_s1;
	logic [cvfc_pkg::CELL_IDX_W-1:0]   cmp_idx_s1;
	logic [cvfc_pkg::MV_W-1:0]         mean_q;
	logic [cvfc_pkg::MV_W-1:0]         best_q;
	logic [cvfc_pkg::CODE_W-1:0]       code_q;
	logic [cvfc_pkg::MV_W-1:0]         diff;
	logic                              last_idx;
	logic                              cmp_last;

	assign diff     = (rdata > mean_q) ? (rdata - mean_q) : (mean_q - rdata);
	assign last_idx = (idx_q == cvfc_pkg::CELL_IDX_W'(cvfc_pkg::CELL_COUNT - 1));
	assign cmp_last = (cmp_idx_s1 == cvfc_pkg::CELL_IDX_W'(cvfc_pkg::CELL_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			done_q     <= cmp_vld_s1 && cmp_last;
			cmp_vld_s1 <= busy_q;
			cmp_idx_s1 <= idx_q;
			if (cmd.start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 1'b1;
				if (last_idx) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mean_q <= cmd.mean;
			best_q <= '0;
			code_q <= cvfc_pkg::NO_CELL;
		end else if (cmp_vld_s1 && (diff > best_q)) begin
			best_q <= diff;
			code_q <= cvfc_pkg::CODE_W'(cmp_idx_s1);
		end
	end

	assign raddr    = idx_q;
	assign res.done = done_q;
	assign res.code = code_q;

endmodule

@@ src/cell_voltage_fault_check_core.sv @@
// cell_voltage_fault_check_core: store items are accepted back to back.
// a check item with no fault leaves the block idle; with over/under faults only it
// goes to ST_EMIT and sends its n results one by one; with a spread fault it first
// scans every cell (CELL_COUNT, 32 here) through the registered read and shared compare unit.
// results leave through one output register; reset makes all cells read as zero
// and loads the default limits (4200, 2500, 300 mV)
module cell_voltage_fault_check_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cvfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cvfc_pkg::MV_W-1:0]        cfg_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic                             kind,
	input  logic [cvfc_pkg::SLOT_W-1:0]      cell_slot,
	input  logic [cvfc_pkg::MV_W-1:0]        cell_mv,
	input  logic [cvfc_pkg::MV_W-1:0]        top_mv,
	input  logic [cvfc_pkg::MV_W-1:0]        bottom_mv,
	input  logic [cvfc_pkg::MV_W-1:0]        mean_mv,
	input  logic [cvfc_pkg::CODE_W-1:0]      top_cell_code,
	input  logic [cvfc_pkg::CODE_W-1:0]      bottom_cell_code,
	output logic                             fault_valid,
	input  logic                             fault_stall,
	output logic [1:0]                       fault_kind,
	output logic [cvfc_pkg::CODE_W-1:0]      fault_cell,
	output logic [cvfc_pkg::MV_W-1:0]        fault_value_mv,
	output logic                             last_fault
);

	cvfc_pkg::state_t                  state_q;
	logic [cvfc_pkg::MV_W-1:0]         over_lim_q;
	logic [cvfc_pkg::MV_W-1:0]         under_lim_q;
	logic [cvfc_pkg::MV_W-1:0]         spread_lim_q;

	logic [2:0]                        pend_q;
	logic [cvfc_pkg::MV_W-1:0]         top_q;
	logic [cvfc_pkg::MV_W-1:0]         bottom_q;
	logic [cvfc_pkg::MV_W-1:0]         spread_q;
	logic [cvfc_pkg::CODE_W-1:0]       top_code_q;
	logic [cvfc_pkg::CODE_W-1:0]       bottom_code_q;
	logic [cvfc_pkg::CODE_W-1:0]       spread_cell_q;

	logic                              out_vld_q;
	cvfc_pkg::fault_kind_t             out_kind_q;
	logic [cvfc_pkg::CODE_W-1:0]       out_cell_q;
	logic [cvfc_pkg::MV_W-1:0]         out_val_q;
	logic                              out_last_q;

	logic                              accept;
	logic                              store_we;
	logic                              over_hit;
	logic                              under_hit;
	logic                              spread_hit;
	logic [cvfc_pkg::MV_W:0]           spread_full;
	logic                              out_load;
	logic [2:0]                        pend_nxt;
	cvfc_pkg::fault_kind_t             sel_kind;
	logic [cvfc_pkg::CODE_W-1:0]       sel_cell;
	logic [cvfc_pkg::MV_W-1:0]         sel_val;

	cvfc_pkg::scan_cmd_t               scan_cmd;
	cvfc_pkg::scan_res_t               scan_res;
	logic [cvfc_pkg::CELL_IDX_W-1:0]   rd_addr;
	logic [cvfc_pkg::MV_W-1:0]         rd_data;

	// config, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_lim_q   <= cvfc_pkg::OVER_RESET;
			under_lim_q  <= cvfc_pkg::UNDER_RESET;
			spread_lim_q <= cvfc_pkg::SPREAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cvfc_pkg::CFG_OVER:   over_lim_q   <= cfg_data;
				cvfc_pkg::CFG_UNDER:  under_lim_q  <= cfg_data;
				cvfc_pkg::CFG_SPREAD: spread_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_stall = (state_q != cvfc_pkg::ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign store_we   = accept && (kind == cvfc_pkg::KIND_STORE)
		&& (int'(cell_slot) < cvfc_pkg::CELL_COUNT);

	assign spread_full = {1'b0, top_mv} - {1'b0, bottom_mv};
	assign over_hit    = top_mv > over_lim_q;
	assign under_hit   = bottom_mv < under_lim_q;
	assign spread_hit  = !spread_full[cvfc_pkg::MV_W]
		&& (spread_full[cvfc_pkg::MV_W-1:0] > spread_lim_q);

	assign scan_cmd.start = accept && (kind == cvfc_pkg::KIND_CHECK) && spread_hit;
	assign scan_cmd.mean  = mean_mv;

	cvfc_cell_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (store_we),
		.waddr  (cvfc_pkg::CELL_IDX_W'(cell_slot)),
		.wdata  (cell_mv),
		.raddr  (rd_addr),
		.rdata  (rd_data)
	);

	cvfc_scan_unit u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (scan_cmd),
		.raddr  (rd_addr),
		.rdata  (rd_data),
		.res    (scan_res)
	);

	// next result in fixed order: over, under, spread
	always_comb begin
		sel_kind = cvfc_pkg::FK_SPREAD;
		sel_cell = spread_cell_q;
		sel_val  = spread_q;
		pend_nxt = pend_q;
		if (pend_q[0]) begin
			sel_kind    = cvfc_pkg::FK_OVER;
			sel_cell    = top_code_q;
			sel_val     = top_q;
			pend_nxt[0] = 1'b0;
		end else if (pend_q[1]) begin
			sel_kind    = cvfc_pkg::FK_UNDER;
			sel_cell    = bottom_code_q;
			sel_val     = bottom_q;
			pend_nxt[1] = 1'b0;
		end else begin
			pend_nxt[2] = 1'b0;
		end
	end

	assign out_load = (state_q == cvfc_pkg::ST_EMIT) && (pend_q != 3'b000)
		&& (!out_vld_q || !fault_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cvfc_pkg::ST_IDLE;
			pend_q    <= 3'b000;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!fault_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				cvfc_pkg::ST_IDLE: begin
					if (accept && (kind == cvfc_pkg::KIND_CHECK)) begin
						pend_q <= {spread_hit, under_hit, over_hit};
						if (spread_hit) begin
							state_q <= cvfc_pkg::ST_SCAN;
						end else if (over_hit || under_hit) begin
							state_q <= cvfc_pkg::ST_EMIT;
						end
					end
				end
				cvfc_pkg::ST_SCAN: begin
					if (scan_res.done) begin
						state_q <= cvfc_pkg::ST_EMIT;
					end
				end
				cvfc_pkg::ST_EMIT: begin
					if (pend_q == 3'b000) begin
						state_q <= cvfc_pkg::ST_IDLE;
					end else if (out_load) begin
						pend_q <= pend_nxt;
					end
				end
				default: begin
					state_q <= cvfc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (kind == cvfc_pkg::KIND_CHECK)) begin
			top_q         <= top_mv;
			bottom_q      <= bottom_mv;
			spread_q      <= spread_full[cvfc_pkg::MV_W-1:0];
			top_code_q    <= top_cell_code;
			bottom_code_q <= bottom_cell_code;
		end
		if (scan_res.done) begin
			spread_cell_q <= scan_res.code;
		end
		if (out_load) begin
			out_kind_q <= sel_kind;
			out_cell_q <= sel_cell;
			out_val_q  <= sel_val;
			out_last_q <= (pend_nxt == 3'b000);
		end
	end

	assign fault_valid    = out_vld_q;
	assign fault_kind     = out_kind_q;
	assign fault_cell     = out_cell_q;
	assign fault_value_mv = out_val_q;
	assign last_fault     = out_last_q;

endmodule

@@ tb/sv/cvfc_fault_watch.sv @@
// cvfc_fault_watch: mirrors the cell store and limits, predicts fault beats, compares them
// watches the config, item and fault channels of cell_voltage_fault_check_core
// depends on cvfc_pkg for widths, codes and the fault kind enum
module cvfc_fault_watch (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [cvfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cvfc_pkg::MV_W-1:0]      cfg_data,
	input  logic                           item_valid,
	input  logic                           item_stall,
	input  logic                           kind,
	input  logic [cvfc_pkg::SLOT_W-1:0]    cell_slot,
	input  logic [cvfc_pkg::MV_W-1:0]      cell_mv,
	input  logic [cvfc_pkg::MV_W-1:0]      top_mv,
	input  logic [cvfc_pkg::MV_W-1:0]      bottom_mv,
	input  logic [cvfc_pkg::MV_W-1:0]      mean_mv,
	input  logic [cvfc_pkg::CODE_W-1:0]    top_cell_code,
	input  logic [cvfc_pkg::CODE_W-1:0]    bottom_cell_code,
	input  logic                           fault_valid,
	input  logic                           fault_stall,
	input  logic [1:0]                     fault_kind,
	input  logic [cvfc_pkg::CODE_W-1:0]    fault_cell,
	input  logic [cvfc_pkg::MV_W-1:0]      fault_value_mv,
	input  logic                           last_fault,
	output int                             mismatches,
	output int                             owed,
	output int                             stores_seen,
	output int                             checks_seen,
	output int                             beats_seen
);
	import cvfc_pkg::*;

	typedef struct packed {
		fault_kind_t       kind;
		logic [CODE_W-1:0] code;
		logic [MV_W-1:0]   value;
		logic              last;
	} fault_beat_t;

	fault_beat_t     owed_faults[$];
	logic [MV_W-1:0] cell_copy[CELL_COUNT];
	logic [MV_W-1:0] over_lim;
	logic [MV_W-1:0] under_lim;
	logic [MV_W-1:0] spread_lim;

	function automatic logic [CODE_W-1:0] furthest_cell_from(input logic [MV_W-1:0] mean);
		logic [MV_W-1:0]   best;
		logic [MV_W-1:0]   d;
		logic [CODE_W-1:0] best_code;
		best      = '0;
		best_code = NO_CELL;
		for (int i = 0; i < CELL_COUNT; i++) begin
			d = (cell_copy[i] > mean) ? cell_copy[i] - mean : mean - cell_copy[i];
			if (d > best) begin
				best      = d;
				best_code = CODE_W'(i);
			end
		end
		return best_code;
	endfunction

	task automatic predict_faults();
		fault_beat_t found[$];
		fault_beat_t b;
		if (kind == KIND_STORE) begin
			stores_seen++;
			if (cell_slot < CELL_COUNT)
				cell_copy[cell_slot] = cell_mv;
		end else begin
			checks_seen++;
			if (top_mv > over_lim) begin
				b = '{FK_OVER, top_cell_code, top_mv, 1'b0};
				found.push_back(b);
			end
			if (bottom_mv < under_lim) begin
				b = '{FK_UNDER, bottom_cell_code, bottom_mv, 1'b0};
				found.push_back(b);
			end
			if (top_mv >= bottom_mv && (top_mv - bottom_mv) > spread_lim) begin
				b = '{FK_SPREAD, furthest_cell_from(mean_mv),
					MV_W'(top_mv - bottom_mv), 1'b0};
				found.push_back(b);
			end
			if (found.size() > 0)
				found[found.size()-1].last = 1'b1;
			foreach (found[i])
				owed_faults.push_back(found[i]);
		end
	endtask

	task automatic compare_beat();
		fault_beat_t w;
		beats_seen++;
		if (owed_faults.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("fault beat with none owed: kind %0d cell %0d value %0d last %0b",
					fault_kind, fault_cell, fault_value_mv, last_fault);
		end else begin
			w = owed_faults.pop_front();
			if (fault_kind !== w.kind || fault_cell !== w.code ||
				fault_value_mv !== w.value || last_fault !== w.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"fault beat mismatch: want kind %0d cell %0d value %0d ",
						"last %0b, got kind %0d cell %0d value %0d last %0b"},
						w.kind, w.code, w.value, w.last,
						fault_kind, fault_cell, fault_value_mv, last_fault);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_faults.delete();
			foreach (cell_copy[i])
				cell_copy[i] = '0;
			over_lim    = OVER_RESET;
			under_lim   = UNDER_RESET;
			spread_lim  = SPREAD_RESET;
			mismatches  = 0;
			owed        = 0;
			stores_seen = 0;
			checks_seen = 0;
			beats_seen  = 0;
		end else begin
			if (fault_valid && !fault_stall)
				compare_beat();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_OVER:   over_lim = cfg_data;
					CFG_UNDER:  under_lim = cfg_data;
					CFG_SPREAD: spread_lim = cfg_data;
					default: ;
				endcase
			end
			if (item_valid && !item_stall)
				predict_faults();
			owed = owed_faults.size();
		end
	end

endmodule

@@ tb/sv/cell_voltage_fault_check_core_test.sv @@
// cell_voltage_fault_check_core_test: drives store and check items and limit writes
// with random gaps and fault stalls; cvfc_fault_watch predicts and compares the beats
// depends on cvfc_pkg, cell_voltage_fault_check_core and cvfc_fault_watch
module cell_voltage_fault_check_core_test;
	import cvfc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 2 * CELL_COUNT + 16;
	localparam int LONG_HOLD   = 400;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] slot;
		logic [MV_W-1:0]   cmv;
		logic [MV_W-1:0]   top;
		logic [MV_W-1:0]   bottom;
		logic [MV_W-1:0]   mean;
		logic [CODE_W-1:0] tcode;
		logic [CODE_W-1:0] bcode;
	} pack_cmd_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MV_W-1:0]      cfg_data;
	logic                 item_valid;
	logic                 item_stall;
	logic                 kind;
	logic [SLOT_W-1:0]    cell_slot;
	logic [MV_W-1:0]      cell_mv;
	logic [MV_W-1:0]      top_mv;
	logic [MV_W-1:0]      bottom_mv;
	logic [MV_W-1:0]      mean_mv;
	logic [CODE_W-1:0]    top_cell_code;
	logic [CODE_W-1:0]    bottom_cell_code;
	logic                 fault_valid;
	logic                 fault_stall;
	logic [1:0]           fault_kind;
	logic [CODE_W-1:0]    fault_cell;
	logic [MV_W-1:0]      fault_value_mv;
	logic                 last_fault;

	int mismatches;
	int owed;
	int stores_seen;
	int checks_seen;
	int beats_seen;

	logic            quiet;
	logic            hold_req;
	logic [MV_W-1:0] cur_over;
	logic [MV_W-1:0] cur_under;
	logic [MV_W-1:0] cur_spread;
	int              settings;
	int              cycles;

	cell_voltage_fault_check_core dut (.*);

	cvfc_fault_watch watch (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d fault beats still owed", cycles, owed);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// fault receiver: random stall bursts, one long hold-off on request
	initial begin
		int burst_left;
		int hold_left;
		burst_left = 0;
		hold_left  = 0;
		fault_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_req) begin
				hold_left = LONG_HOLD;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				fault_stall <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				fault_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(1, 8) - 1;
				fault_stall <= 1'b1;
			end else begin
				fault_stall <= 1'b0;
			end
		end
	end

	function automatic pack_cmd_t noise_cmd();
		pack_cmd_t c;
		c.kind   = 1'($urandom_range(0, 1));
		c.slot   = SLOT_W'($urandom);
		c.cmv    = MV_W'($urandom);
		c.top    = MV_W'($urandom);
		c.bottom = MV_W'($urandom);
		c.mean   = MV_W'($urandom);
		c.tcode  = CODE_W'($urandom);
		c.bcode  = CODE_W'($urandom);
		return c;
	endfunction

	function automatic logic [MV_W-1:0] clamp_mv(input int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return '1;
		return MV_W'(v);
	endfunction

	task automatic send_cmd(input pack_cmd_t c);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid       <= 1'b1;
		kind             <= c.kind;
		cell_slot        <= c.slot;
		cell_mv          <= c.cmv;
		top_mv           <= c.top;
		bottom_mv        <= c.bottom;
		mean_mv          <= c.mean;
		top_cell_code    <= c.tcode;
		bottom_cell_code <= c.bcode;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic store_reading(input logic [SLOT_W-1:0] slot, input logic [MV_W-1:0] mv);
		pack_cmd_t c;
		c      = noise_cmd();
		c.kind = KIND_STORE;
		c.slot = slot;
		c.cmv  = mv;
		send_cmd(c);
	endtask

	task automatic run_check(input logic [MV_W-1:0] top, input logic [MV_W-1:0] bottom,
		input logic [MV_W-1:0] mean, input logic [CODE_W-1:0] tcode,
		input logic [CODE_W-1:0] bcode);
		pack_cmd_t c;
		c        = noise_cmd();
		c.kind   = KIND_CHECK;
		c.top    = top;
		c.bottom = bottom;
		c.mean   = mean;
		c.tcode  = tcode;
		c.bcode  = bcode;
		send_cmd(c);
	endtask

	task automatic random_store();
		logic [MV_W-1:0] mv;
		case ($urandom_range(0, 3))
			0:       mv = MV_W'($urandom);
			1:       mv = ($urandom_range(0, 1) == 1) ? 16'd3000 : 16'd3600;
			default: mv = MV_W'($urandom_range(2800, 4300));
		endcase
		store_reading(SLOT_W'($urandom), mv);
	endtask

	task automatic random_check();
		int t;
		int b;
		int m;
		case ($urandom_range(0, 4))
			0: begin
				t = int'(cur_over) + int'($urandom_range(0, 6)) - 3;
				b = int'(cur_under) + int'($urandom_range(0, 6)) - 3;
			end
			1: begin
				b = $urandom_range(2000, 4000);
				t = b + int'(cur_spread) + int'($urandom_range(0, 2)) - 1;
			end
			2: begin
				t = $urandom_range(0, 65535);
				b = $urandom_range(0, 65535);
			end
			default: begin
				b = $urandom_range(2000, 4000);
				t = b + int'($urandom_range(0, 700));
			end
		endcase
		t = int'(clamp_mv(t));
		b = int'(clamp_mv(b));
		if ($urandom_range(0, 3) == 0)
			m = $urandom_range(0, 65535);
		else
			m = $urandom_range(b, t);
		run_check(MV_W'(t), MV_W'(b), MV_W'(m), CODE_W'($urandom), CODE_W'($urandom));
	endtask

	task automatic random_items(input int count, input int check_pct);
		repeat (count) begin
			if ($urandom_range(0, 99) < check_pct)
				random_check();
			else
				random_store();
		end
	endtask

	// lets the block go idle before a limit write or the verdict
	task automatic drain_faults();
		@(negedge clk);
		item_valid <= 1'b0;
		while (owed != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_OVER:   cur_over = val;
			CFG_UNDER:  cur_under = val;
			CFG_SPREAD: cur_spread = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(input logic [MV_W-1:0] over, input logic [MV_W-1:0] under,
		input logic [MV_W-1:0] spread);
		drain_faults();
		write_limit(CFG_OVER, over);
		write_limit(CFG_UNDER, under);
		write_limit(CFG_SPREAD, spread);
		settings++;
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_valid        = 1'b0;
		cfg_index        = CFG_OVER;
		cfg_data         = '0;
		item_valid       = 1'b0;
		kind             = KIND_STORE;
		cell_slot        = '0;
		cell_mv          = '0;
		top_mv           = '0;
		bottom_mv        = '0;
		mean_mv          = '0;
		top_cell_code    = '0;
		bottom_cell_code = '0;
		quiet            = 1'b0;
		hold_req         = 1'b0;
		cur_over         = OVER_RESET;
		cur_under        = UNDER_RESET;
		cur_spread       = SPREAD_RESET;
		settings         = 1;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset limits
		run_check(16'd4100, 16'd3000, 16'd0, 8'hFF, 8'h00);
		store_reading(5'd5, 16'd1000);
		store_reading(5'd9, 16'd1000);
		run_check(16'd4100, 16'd3700, 16'd0, 8'd1, 8'd2);
		store_reading(5'd31, 16'hFFFF);
		store_reading(5'd16, 16'h5555);
		store_reading(5'd0, 16'h0000);
		run_check(16'd4100, 16'd3700, 16'd0, 8'd3, 8'd4);
		run_check(16'd4200, 16'd3900, 16'd4000, 8'd7, 8'd8);
		run_check(16'd4201, 16'd3950, 16'd4000, 8'hAA, 8'h55);
		run_check(16'd2700, 16'd2499, 16'd2600, 8'h00, 8'hFF);
		run_check(16'hFFFF, 16'h0000, 16'h8000, 8'hFF, 8'hFF);
		run_check(16'd3000, 16'd3500, 16'd3200, 8'h0F, 8'hF0);
		run_check(16'h0000, 16'hFFFF, 16'h0000, 8'h00, 8'h00);
		run_check(16'd4300, 16'd2000, 16'hFFFF, 8'h11, 8'h22);
		store_reading(5'd31, 16'd0);
		store_reading(5'd5, 16'd0);
		store_reading(5'd9, 16'd0);
		store_reading(5'd16, 16'd0);
		run_check(16'd4000, 16'd3000, 16'd0, 8'h33, 8'h44);
		run_check(16'd4000, 16'd3000, 16'hFFFF, 8'h55, 8'h66);

		// any check with top > bottom trips all three; long hold-off fills the block
		set_limits(16'd0, 16'hFFFF, 16'd0);
		random_items(20, 40);
		@(posedge clk);
		hold_req = 1'b1;
		repeat (30) random_check();

		// nothing can trip
		set_limits(16'hFFFF, 16'd0, 16'hFFFF);
		random_items(30, 40);

		set_limits(OVER_RESET, UNDER_RESET, SPREAD_RESET);
		random_items(40, 30);

		set_limits(MV_W'($urandom_range(3500, 4500)), MV_W'($urandom_range(2000, 3000)),
			MV_W'($urandom_range(0, 1000)));
		random_items(40, 30);

		set_limits(MV_W'($urandom), MV_W'($urandom), MV_W'($urandom));
		random_items(30, 40);

		// final stretch without idling on either side
		set_limits(MV_W'($urandom_range(3800, 4300)), MV_W'($urandom_range(2200, 2800)),
			MV_W'($urandom_range(100, 600)));
		@(posedge clk);
		quiet = 1'b1;
		random_items(50, 30);

		drain_faults();
		$display("covered %0d store beats and %0d check beats, %0d fault beats compared",
			stores_seen, checks_seen, beats_seen);
		$display("limits swept through %0d settings, all-trip and never-trip among them",
			settings);
		if (mismatches == 0 && owed == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
